>>> hdl/rvce_pkg.sv
// Package for the power-rail voltage code encoder: widths, span tables,
// rail constants and the stage-one pick structure. No dependencies.
package rvce_pkg;

   localparam int IDX_W    = 4;
   localparam int MV_W     = 16;
   localparam int SPAN_W   = 12;
   localparam int OFF_W    = 12;
   localparam int Q10_W    = 9;
   localparam int ADDR_W   = 8;
   localparam int CODE_W   = 7;
   localparam int MASK_W   = 8;

   localparam int SW_RAIL_COUNT  = 5;
   localparam int LIN_RAIL_COUNT = 9;
   localparam int SW_SPAN_COUNT  = 9;
   localparam int SW_MAX_SPANS   = 3;

   localparam logic [ADDR_W-1:0] SW_ADDR_BASE  = 8'h82;
   localparam logic [ADDR_W-1:0] LIN_ADDR_BASE = 8'h92;
   localparam logic [MASK_W-1:0] MASK_NONE     = 8'h00;
   localparam logic [MASK_W-1:0] MASK_HIGH1    = 8'h80;
   localparam logic [MASK_W-1:0] MASK_HIGH3    = 8'hE0;

   localparam logic [2:0]        SPECIAL_RAIL = 3'd4;
   localparam logic [MV_W-1:0]   SPECIAL_MV   = 16'd1200;
   localparam logic [CODE_W-1:0] SPECIAL_CODE = 7'h19;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   typedef enum logic [1:0] {
      STEP_10,
      STEP_20,
      STEP_50,
      STEP_100
   } step_type;

   typedef struct packed {
      logic [SPAN_W-1:0] lo;
      logic [SPAN_W-1:0] hi;
      step_type          step;
      logic [CODE_W-1:0] base;
   } span_type;

   typedef struct packed {
      logic              rail_ok;
      logic              hit;
      logic              special;
      logic [ADDR_W-1:0] addr;
      logic [MASK_W-1:0] keep;
      logic [SPAN_W-1:0] lo;
      step_type          step;
      logic [CODE_W-1:0] base;
   } span_pick_type;

   localparam span_type SW_SPANS [SW_SPAN_COUNT] = '{
      '{12'd1500, 12'd3400, STEP_100, 7'd0},
      '{12'd500,  12'd1200, STEP_10,  7'd0},
      '{12'd1220, 12'd1540, STEP_20,  7'd71},
      '{12'd500,  12'd1200, STEP_10,  7'd0},
      '{12'd1220, 12'd1540, STEP_20,  7'd71},
      '{12'd1600, 12'd3400, STEP_100, 7'd88},
      '{12'd500,  12'd1200, STEP_10,  7'd0},
      '{12'd1220, 12'd1840, STEP_20,  7'd71},
      '{12'd1400, 12'd3700, STEP_100, 7'd0}
   };

   localparam logic [3:0] SW_FIRST [SW_RAIL_COUNT] = '{4'd0, 4'd1, 4'd3, 4'd6, 4'd8};
   localparam logic [1:0] SW_COUNT [SW_RAIL_COUNT] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd1};
   localparam logic [MASK_W-1:0] SW_KEEP [SW_RAIL_COUNT] =
      '{MASK_NONE, MASK_HIGH1, MASK_HIGH1, MASK_HIGH1, MASK_HIGH3};

   localparam span_type LIN_SPANS [LIN_RAIL_COUNT] = '{
      '{12'd500, 12'd3500, STEP_100, 7'd0},
      '{12'd500, 12'd3500, STEP_100, 7'd0},
      '{12'd500, 12'd3500, STEP_100, 7'd0},
      '{12'd500, 12'd3500, STEP_100, 7'd0},
      '{12'd500, 12'd3500, STEP_100, 7'd0},
      '{12'd500, 12'd3500, STEP_100, 7'd0},
      '{12'd500, 12'd1400, STEP_50,  7'd0},
      '{12'd500, 12'd3400, STEP_100, 7'd0},
      '{12'd500, 12'd3400, STEP_100, 7'd0}
   };

endpackage

>>> hdl/rvce_req_if.sv
// Request channel interface: valid/ready plus rail and voltage payload.
// Depends on rvce_pkg.
interface rvce_req_if;
   logic                       valid;
   logic                       ready;
   logic                       rail_kind;
   logic [rvce_pkg::IDX_W-1:0] rail_index;
   logic [rvce_pkg::MV_W-1:0]  millivolts;

   modport source (output valid, rail_kind, rail_index, millivolts, input ready);
   modport sink   (input valid, rail_kind, rail_index, millivolts, output ready);
endinterface

>>> hdl/rvce_rsp_if.sv
// Response channel interface: valid/ready plus status, address, code, mask.
// Depends on rvce_pkg.
interface rvce_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        status;
   logic [rvce_pkg::ADDR_W-1:0] reg_address;
   logic [rvce_pkg::CODE_W-1:0] voltage_code;
   logic [rvce_pkg::MASK_W-1:0] keep_mask;

   modport source (output valid, status, reg_address, voltage_code, keep_mask, input ready);
   modport sink   (input valid, status, reg_address, voltage_code, keep_mask, output ready);
endinterface

>>> hdl/rvce_span_sel.sv
// Rail decode and first-matching span pick (combinational stage-one logic).
// Depends on rvce_pkg span tables.
module rvce_span_sel (
   input  logic                       rail_kind,
   input  logic [rvce_pkg::IDX_W-1:0] rail_index,
   input  logic [rvce_pkg::MV_W-1:0]  millivolts,
   output rvce_pkg::span_pick_type    pick
);
   import rvce_pkg::*;

   always_comb begin
      logic [2:0] sw_rail;
      logic [3:0] slot;
      span_type   sp;

      pick    = '0;
      sw_rail = '0;
      slot    = '0;
      sp      = '0;
      if (!rail_kind) begin
         if (rail_index < IDX_W'(SW_RAIL_COUNT)) begin
            sw_rail      = rail_index[2:0];
            pick.rail_ok = 1'b1;
            pick.addr    = SW_ADDR_BASE + ADDR_W'(rail_index);
            pick.keep    = SW_KEEP[sw_rail];
            pick.special = (sw_rail == SPECIAL_RAIL) && (millivolts == SPECIAL_MV);
            for (int i = 0; i < SW_MAX_SPANS; i++) begin
               if (!pick.hit && (2'(i) < SW_COUNT[sw_rail])) begin
                  slot = SW_FIRST[sw_rail] + 4'(i);
                  sp   = SW_SPANS[slot];
                  if (millivolts >= MV_W'(sp.lo) && millivolts <= MV_W'(sp.hi)) begin
                     pick.hit  = 1'b1;
                     pick.lo   = sp.lo;
                     pick.step = sp.step;
                     pick.base = sp.base;
                  end
               end
            end
         end
      end else begin
         if (rail_index < IDX_W'(LIN_RAIL_COUNT)) begin
            sp           = LIN_SPANS[rail_index];
            pick.rail_ok = 1'b1;
            pick.addr    = LIN_ADDR_BASE + ADDR_W'(rail_index);
            pick.keep    = MASK_HIGH3;
            if (millivolts >= MV_W'(sp.lo) && millivolts <= MV_W'(sp.hi)) begin
               pick.hit  = 1'b1;
               pick.lo   = sp.lo;
               pick.step = sp.step;
               pick.base = sp.base;
            end
         end
      end
   end

endmodule

>>> hdl/regulator_voltage_code_encoder.sv
// Top level of the power-rail voltage code encoder: four-stage pipeline.
// Depends on rvce_pkg, rvce_req_if, rvce_rsp_if, rvce_span_sel.
//
//   channel   role   payload
//   req_bus   in     rail_kind, rail_index, millivolts
//   rsp_bus   out    status, reg_address, voltage_code, keep_mask
//
// One beat in and one beat out per cycle while rsp_bus.ready is high; a beat
// passes through the span pick, offset subtract, divide-by-ten and step-scale stages.
// Each stage holds a valid bit; an empty stage fills even while later ones
// stall, so bubbles collapse and rsp_bus.ready low stalls only full stages.
// Synchronous reset clears the valid bits only.
module regulator_voltage_code_encoder (
   input logic        clock,
   input logic        reset,
   rvce_req_if.sink   req_bus,
   rvce_rsp_if.source rsp_bus
);
   import rvce_pkg::*;

   span_pick_type pick;

   logic en1, en2, en3, en4;

   logic              v1_ff;
   span_pick_type     pick1_ff;
   logic [MV_W-1:0]   mv1_ff;

   logic              v2_ff;
   logic              ok2_ff, special2_ff;
   logic [ADDR_W-1:0] addr2_ff;
   logic [MASK_W-1:0] keep2_ff;
   step_type          step2_ff;
   logic [CODE_W-1:0] base2_ff;
   logic [OFF_W-1:0]  off2_ff;

   logic              v3_ff;
   logic              ok3_ff, special3_ff;
   logic [ADDR_W-1:0] addr3_ff;
   logic [MASK_W-1:0] keep3_ff;
   step_type          step3_ff;
   logic [CODE_W-1:0] base3_ff;
   logic [Q10_W-1:0]  q10_ff;
   logic              r10z_ff;

   logic              v4_ff;
   logic              status4_ff;
   logic [ADDR_W-1:0] addr4_ff;
   logic [CODE_W-1:0] code4_ff;
   logic [MASK_W-1:0] keep4_ff;

   logic [OFF_W-1:0]  off2_in;
   logic [23:0]       q10_prod;
   logic [Q10_W-1:0]  q10_in;
   logic              r10z_in;
   logic              status4_in;
   logic [ADDR_W-1:0] addr4_in;
   logic [CODE_W-1:0] code4_in;
   logic [MASK_W-1:0] keep4_in;

   rvce_span_sel u_span_sel (
      .rail_kind  (req_bus.rail_kind),
      .rail_index (req_bus.rail_index),
      .millivolts (req_bus.millivolts),
      .pick       (pick)
   );

   assign en4 = !v4_ff || rsp_bus.ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_bus.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // stage 1: span pick
   always_ff @(posedge clock) begin
      if (en1) begin
         pick1_ff <= pick;
         mv1_ff   <= req_bus.millivolts;
      end
   end

   // stage 2: offset into span
   assign off2_in = OFF_W'(mv1_ff - MV_W'(pick1_ff.lo));

   always_ff @(posedge clock) begin
      if (en2) begin
         ok2_ff      <= pick1_ff.rail_ok && (pick1_ff.hit || pick1_ff.special);
         special2_ff <= pick1_ff.special;
         addr2_ff    <= pick1_ff.addr;
         keep2_ff    <= pick1_ff.keep;
         step2_ff    <= pick1_ff.step;
         base2_ff    <= pick1_ff.base;
         off2_ff     <= off2_in;
      end
   end

   // stage 3: offset / 10 as multiply by 3277 / 2^15, exact for 12-bit offsets
   assign q10_prod = 24'(off2_ff) * 24'd3277;
   assign q10_in   = q10_prod[15 +: Q10_W];
   assign r10z_in  = (OFF_W'(q10_in * 12'd10) == off2_ff);

   always_ff @(posedge clock) begin
      if (en3) begin
         ok3_ff      <= ok2_ff;
         special3_ff <= special2_ff;
         addr3_ff    <= addr2_ff;
         keep3_ff    <= keep2_ff;
         step3_ff    <= step2_ff;
         base3_ff    <= base2_ff;
         q10_ff      <= q10_in;
         r10z_ff     <= r10z_in;
      end
   end

   // stage 4: scale to step, add base, format result
   // /5 and /10 of a 9-bit quotient: multiply by 205, shift by 10 or 11
   always_comb begin
      logic [Q10_W-1:0] q;
      logic             rz;
      logic             ok;
      logic [19:0]      prod;

      prod = 20'(q10_ff) * 20'd205;
      q    = q10_ff;
      rz   = 1'b1;
      unique case (step3_ff)
         STEP_10: begin
            q  = q10_ff;
            rz = 1'b1;
         end
         STEP_20: begin
            q  = q10_ff >> 1;
            rz = !q10_ff[0];
         end
         STEP_50: begin
            q  = prod[10 +: Q10_W];
            rz = (Q10_W'(q * 9'd5) == q10_ff);
         end
         STEP_100: begin
            q  = prod[11 +: Q10_W];
            rz = (Q10_W'(q * 9'd10) == q10_ff);
         end
         default: begin
            q  = q10_ff;
            rz = 1'b0;
         end
      endcase
      ok = ok3_ff && (special3_ff || (r10z_ff && rz));
      if (ok) begin
         status4_in = STATUS_OK;
         addr4_in   = addr3_ff;
         keep4_in   = keep3_ff;
         code4_in   = special3_ff ? SPECIAL_CODE : CODE_W'(base3_ff + CODE_W'(q));
      end else begin
         status4_in = STATUS_INVALID;
         addr4_in   = '0;
         keep4_in   = '0;
         code4_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         status4_ff <= status4_in;
         addr4_ff   <= addr4_in;
         code4_ff   <= code4_in;
         keep4_ff   <= keep4_in;
      end
   end

   assign rsp_bus.valid        = v4_ff;
   assign rsp_bus.status       = status4_ff;
   assign rsp_bus.reg_address  = addr4_ff;
   assign rsp_bus.voltage_code = code4_ff;
   assign rsp_bus.keep_mask    = keep4_ff;

endmodule

>>> hdl/rvce_checker.sv
// Port-level checks on the voltage code encoder, bound to the top level.
// Depends on rvce_pkg and regulator_voltage_code_encoder.
module rvce_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_status,
   input logic [rvce_pkg::ADDR_W-1:0] rsp_reg_address,
   input logic [rvce_pkg::CODE_W-1:0] rsp_voltage_code,
   input logic [rvce_pkg::MASK_W-1:0] rsp_keep_mask
);
   import rvce_pkg::*;

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_reg_address) && $stable(rsp_voltage_code) && $stable(rsp_keep_mask))
      else $error("stalled rsp beat changed");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_INVALID |->
      rsp_reg_address == '0 && rsp_voltage_code == '0 && rsp_keep_mask == '0)
      else $error("invalid status with nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
      (rsp_reg_address >= SW_ADDR_BASE &&
       rsp_reg_address < SW_ADDR_BASE + ADDR_W'(SW_RAIL_COUNT)) ||
      (rsp_reg_address >= LIN_ADDR_BASE &&
       rsp_reg_address < LIN_ADDR_BASE + ADDR_W'(LIN_RAIL_COUNT)))
      else $error("ok beat with bad register address");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK && rsp_reg_address >= LIN_ADDR_BASE |->
      rsp_keep_mask == MASK_HIGH3)
      else $error("linear rail beat with wrong keep mask");

endmodule

bind regulator_voltage_code_encoder rvce_checker u_rvce_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_reg_address  (rsp_bus.reg_address),
   .rsp_voltage_code (rsp_bus.voltage_code),
   .rsp_keep_mask    (rsp_bus.keep_mask)
);

>>> tb/regulator_voltage_code_encoder_tb.sv
`timescale 1ns / 100ps
// Testbench for regulator_voltage_code_encoder: directed and random rail
// requests, each result checked against a local encoder model.
// Depends on rvce_pkg, rvce_req_if, rvce_rsp_if and the encoder RTL.
module regulator_voltage_code_encoder_tb;
   import rvce_pkg::*;

   localparam logic KIND_SWITCHING = 1'b0;
   localparam logic KIND_LINEAR    = 1'b1;
   localparam int   IDLE_PERCENT   = 31;
   localparam int   RANDOM_ITEMS   = 1675;
   localparam int   STEADY_ITEMS   = 300;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   DRAIN_CYCLES   = 12;
   localparam int   REPORT_LIMIT   = 200;

   typedef struct packed {
      int lo;
      int hi;
      int stp;
      int bse;
   } rail_range;

   typedef struct packed {
      logic              status;
      logic [ADDR_W-1:0] reg_address;
      logic [CODE_W-1:0] voltage_code;
      logic [MASK_W-1:0] keep_mask;
   } rail_word;

   localparam rail_range SW_RANGES [9] = '{
      '{1500, 3400, 100, 0},
      '{500, 1200, 10, 0}, '{1220, 1540, 20, 71},
      '{500, 1200, 10, 0}, '{1220, 1540, 20, 71}, '{1600, 3400, 100, 88},
      '{500, 1200, 10, 0}, '{1220, 1840, 20, 71},
      '{1400, 3700, 100, 0}
   };
   localparam int SW_RANGE_FIRST [SW_RAIL_COUNT] = '{0, 1, 3, 6, 8};
   localparam int SW_RANGE_COUNT [SW_RAIL_COUNT] = '{1, 2, 3, 2, 1};
   localparam rail_range LIN_RANGES [LIN_RAIL_COUNT] = '{
      '{500, 3500, 100, 0}, '{500, 3500, 100, 0}, '{500, 3500, 100, 0},
      '{500, 3500, 100, 0}, '{500, 3500, 100, 0}, '{500, 3500, 100, 0},
      '{500, 1400, 50, 0},  '{500, 3400, 100, 0}, '{500, 3400, 100, 0}
   };

   logic clock;
   logic reset;
   bit   steady_flow = 1'b0;
   int   error_count = 0;
   int   quiet_cycles = 0;
   rail_word expected_words [$];

   rvce_req_if req_bus ();
   rvce_rsp_if rsp_bus ();

   regulator_voltage_code_encoder DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void match_range(input rail_range r, input int mv, inout bit found,
                                       inout bit ok, inout int code);
      if (!found && mv >= r.lo && mv <= r.hi) begin
         found = 1'b1;
         ok    = ((mv - r.lo) % r.stp) == 0;
         code  = r.bse + (mv - r.lo) / r.stp;
      end
   endfunction

   function automatic rail_word encode_rail(input logic kind, input logic [IDX_W-1:0] idx,
                                            input logic [MV_W-1:0] mv);
      rail_word w;
      bit found;
      bit ok;
      int code;
      int n;
      w     = '0;
      found = 1'b0;
      ok    = 1'b0;
      code  = 0;
      if (kind == KIND_SWITCHING) begin
         if (idx < IDX_W'(SW_RAIL_COUNT)) begin
            w.reg_address = SW_ADDR_BASE + ADDR_W'(idx);
            w.keep_mask   = (idx == 0) ? MASK_NONE :
                            (idx == IDX_W'(SPECIAL_RAIL)) ? MASK_HIGH3 : MASK_HIGH1;
            if (idx == IDX_W'(SPECIAL_RAIL) && mv == SPECIAL_MV) begin
               ok   = 1'b1;
               code = int'(SPECIAL_CODE);
            end else begin
               for (n = 0; n < SW_RANGE_COUNT[idx]; n++)
                  match_range(SW_RANGES[SW_RANGE_FIRST[idx] + n], mv, found, ok, code);
            end
         end
      end else if (idx < IDX_W'(LIN_RAIL_COUNT)) begin
         w.reg_address = LIN_ADDR_BASE + ADDR_W'(idx);
         w.keep_mask   = MASK_HIGH3;
         match_range(LIN_RANGES[idx], mv, found, ok, code);
      end
      if (ok) begin
         w.status       = STATUS_OK;
         w.voltage_code = CODE_W'(code);
      end else begin
         w = '0;
         w.status = STATUS_INVALID;
      end
      return w;
   endfunction

   task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx,
                               input logic [MV_W-1:0] mv);
      while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.rail_kind  <= kind;
      req_bus.rail_index <= idx;
      req_bus.millivolts <= mv;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      expected_words.push_back(encode_rail(kind, idx, mv));
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_results
      rail_word want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_words.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("%0t: unexpected beat, expected none, actual %0h/%0h/%0h/%0h", $time,
                        rsp_bus.status, rsp_bus.reg_address, rsp_bus.voltage_code,
                        rsp_bus.keep_mask);
         end else begin
            want = expected_words.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("reg_address", want.reg_address, rsp_bus.reg_address);
            check_field("voltage_code", want.voltage_code, rsp_bus.voltage_code);
            check_field("keep_mask", want.keep_mask, rsp_bus.keep_mask);
         end
      end
   end

   always @(posedge clock)
      rsp_bus.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_range_limits();
      send_request(KIND_SWITCHING, 0, 1500);
      send_request(KIND_SWITCHING, 0, 3400);
      send_request(KIND_SWITCHING, 1, 500);
      send_request(KIND_SWITCHING, 1, 1540);
      send_request(KIND_SWITCHING, 2, 1600);
      send_request(KIND_SWITCHING, 2, 3400);
      send_request(KIND_SWITCHING, 3, 1840);
      send_request(KIND_SWITCHING, 4, 1400);
      send_request(KIND_SWITCHING, 4, 3700);
      send_request(KIND_LINEAR, 0, 500);
      send_request(KIND_LINEAR, 5, 3500);
      send_request(KIND_LINEAR, 6, 1400);
      send_request(KIND_LINEAR, 8, 3400);
   endtask

   task automatic test_invalid_voltages();
      send_request(KIND_SWITCHING, 0, 0);
      send_request(KIND_SWITCHING, 1, 1210);
      send_request(KIND_SWITCHING, 1, 505);
      send_request(KIND_SWITCHING, 2, 1560);
      send_request(KIND_LINEAR, 6, 1450);
      send_request(KIND_LINEAR, 7, 3500);
      send_request(KIND_LINEAR, 0, 16'hFFFF);
   endtask

   task automatic test_invalid_rails();
      send_request(KIND_SWITCHING, 5, 2000);
      send_request(KIND_SWITCHING, 15, 16'hFFFF);
      send_request(KIND_LINEAR, 9, 1000);
      send_request(KIND_LINEAR, 15, 0);
   endtask

   task automatic test_special_voltage();
      send_request(KIND_SWITCHING, IDX_W'(SPECIAL_RAIL), SPECIAL_MV);
      send_request(KIND_SWITCHING, IDX_W'(SPECIAL_RAIL), 1300);
      send_request(KIND_SWITCHING, 3, 1200);
   endtask

   task automatic test_random_requests(input int count);
      logic             kind;
      logic [IDX_W-1:0] idx;
      logic [MV_W-1:0]  mv;
      rail_range        r;
      int               pick;
      for (int i = 0; i < count; i++) begin
         steady_flow = (i >= count / 2) && (i < count / 2 + STEADY_ITEMS);
         pick = $urandom_range(99);
         kind = 1'($urandom_range(1));
         idx  = (kind == KIND_SWITCHING) ? IDX_W'($urandom_range(SW_RAIL_COUNT - 1))
                                         : IDX_W'($urandom_range(LIN_RAIL_COUNT - 1));
         mv   = MV_W'($urandom_range(3900, 300));
         if (pick < 70) begin
            if (kind == KIND_SWITCHING)
               r = SW_RANGES[SW_RANGE_FIRST[idx] + $urandom_range(SW_RANGE_COUNT[idx] - 1)];
            else
               r = LIN_RANGES[idx];
            mv = MV_W'(r.lo + r.stp * $urandom_range((r.hi - r.lo) / r.stp));
         end else if (pick < 85 && pick >= 82) begin
            kind = KIND_SWITCHING;
            idx  = IDX_W'(SPECIAL_RAIL);
            mv   = SPECIAL_MV;
         end else if (pick >= 85 && pick < 92) begin
            idx = (kind == KIND_SWITCHING) ? IDX_W'($urandom_range(15, SW_RAIL_COUNT))
                                           : IDX_W'($urandom_range(15, LIN_RAIL_COUNT));
            mv  = MV_W'($urandom);
         end else if (pick >= 92) begin
            idx = IDX_W'($urandom_range(15));
            mv  = MV_W'($urandom);
         end
         send_request(kind, idx, mv);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.rail_kind  <= KIND_SWITCHING;
      req_bus.rail_index <= '0;
      req_bus.millivolts <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_range_limits();
      test_invalid_voltages();
      test_invalid_rails();
      test_special_voltage();
      test_random_requests(RANDOM_ITEMS);
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
